@@ hw/rtl/lqdp_pkg.sv @@
// Shared types, codes and constants of the level-qualified duty pump control unit.
package lqdp_pkg;

   // Widths fixed by the item and register fields.
   localparam int TimeWidth        = 32;
   localparam int CsrDataWidth     = 32;
   localparam int CsrIndexWidth    = 2;
   localparam int DemandWidth      = 2;
   localparam int PumpCountDefault = 6;

   typedef logic [TimeWidth-1:0] time_type;

   // Register reset values.
   localparam time_type LevelDelayReset   = 32'd1000;
   localparam time_type StartupLimitReset = 32'd5000;

   // Level decision reported with every result item.
   typedef enum logic [DemandWidth-1:0] {
      DEMAND_STOP = 2'd0,
      DEMAND_RUN  = 2'd1,
      DEMAND_HOLD = 2'd2
   } demand_type;

   // Configuration register indexes.
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_LEVEL_DELAY   = 2'd0,
      CSR_STARTUP_LIMIT = 2'd1,
      CSR_DUTY_MASK     = 2'd2,
      CSR_PRESENT_MASK  = 2'd3
   } csr_index_type;

   // Qualification status of one float switch.
   typedef struct packed {
      logic qual_on;
      logic qual_off;
   } level_qual_type;

endpackage

@@ hw/rtl/level_qualified_duty_pump_control_unit.sv @@
// Top level of the level-qualified duty pump control unit.
//
// Each tick item carries a millisecond time, the low and high float switch
// levels and the running feedback of each pump, and produces exactly one
// result item: the pump enable mask after the tick, the start-fault mask and
// the level decision (stop all, run duty, hold). An accepted item goes into an
// input register, is evaluated by the switch trackers and the pump lanes, and
// lands in the result register, so the unit takes one item per cycle while
// rsp_ready keeps the result register draining. The result register lets the
// next item be taken while a finished result waits. The user must write
// configuration through the csr_ port only while no item is in flight; the
// unit does not enforce this, and there is no clearing pass after reset.
module level_qualified_duty_pump_control_unit #(
   parameter int PUMP_COUNT = lqdp_pkg::PumpCountDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Tick items
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [lqdp_pkg::TimeWidth-1:0]        req_now_ms,
   input  logic                                  req_low_switch_on,
   input  logic                                  req_high_switch_on,
   input  logic [PUMP_COUNT-1:0]                 req_running_mask,
   // Result items
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [PUMP_COUNT-1:0]                 rsp_enable_mask,
   output logic [PUMP_COUNT-1:0]                 rsp_start_fault_mask,
   output logic [lqdp_pkg::DemandWidth-1:0]      rsp_demand,
   // Configuration writes
   input  logic                                  csr_write,
   input  logic [lqdp_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [lqdp_pkg::CsrDataWidth-1:0]     csr_data
);

   // Configuration registers.
   lqdp_pkg::time_type    level_delay_ff;
   lqdp_pkg::time_type    startup_limit_ff;
   logic [PUMP_COUNT-1:0] duty_mask_ff;
   logic [PUMP_COUNT-1:0] present_mask_ff;

   // Input register.
   logic                  in_valid_ff;
   logic                  in_valid_in;
   lqdp_pkg::time_type    now_ff;
   logic                  low_on_ff;
   logic                  high_on_ff;
   logic [PUMP_COUNT-1:0] running_ff;

   // Result register.
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [PUMP_COUNT-1:0] enable_ff;
   logic [PUMP_COUNT-1:0] fault_ff;
   lqdp_pkg::demand_type  demand_ff;

   logic                     req_fire;
   logic                     advance;
   lqdp_pkg::level_qual_type low_qual;
   lqdp_pkg::level_qual_type high_qual;
   lqdp_pkg::demand_type     demand;
   logic [PUMP_COUNT-1:0]    enable_next;
   logic [PUMP_COUNT-1:0]    fault_next;

   // Configuration write decode.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_delay_ff   <= lqdp_pkg::LevelDelayReset;
         startup_limit_ff <= lqdp_pkg::StartupLimitReset;
         duty_mask_ff     <= '0;
         present_mask_ff  <= '0;
      end else if (csr_write) begin
         case (lqdp_pkg::csr_index_type'(csr_index))
            lqdp_pkg::CSR_LEVEL_DELAY: begin
               level_delay_ff <= csr_data[lqdp_pkg::TimeWidth-1:0];
            end
            lqdp_pkg::CSR_STARTUP_LIMIT: begin
               startup_limit_ff <= csr_data[lqdp_pkg::TimeWidth-1:0];
            end
            lqdp_pkg::CSR_DUTY_MASK: begin
               duty_mask_ff <= csr_data[PUMP_COUNT-1:0];
            end
            lqdp_pkg::CSR_PRESENT_MASK: begin
               present_mask_ff <= csr_data[PUMP_COUNT-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Handshake: the held item moves on when the result register is free or
   // being emptied this cycle.
   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
      req_ready    = !in_valid_ff || advance;
      req_fire     = req_valid && req_ready;
      in_valid_in  = req_fire || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture an accepted item.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         now_ff     <= req_now_ms;
         low_on_ff  <= req_low_switch_on;
         high_on_ff <= req_high_switch_on;
         running_ff <= req_running_mask;
      end
   end

   // Switch trackers.
   lqdp_level_qual u_low_qual (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .now_ms         (now_ff),
      .switch_on      (low_on_ff),
      .level_delay_ms (level_delay_ff),
      .qual           (low_qual)
   );

   lqdp_level_qual u_high_qual (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .now_ms         (now_ff),
      .switch_on      (high_on_ff),
      .level_delay_ms (level_delay_ff),
      .qual           (high_qual)
   );

   // Level decision from both switches.
   always_comb begin
      if (low_qual.qual_off && high_qual.qual_off) begin
         demand = lqdp_pkg::DEMAND_STOP;
      end else if (low_qual.qual_on && high_qual.qual_on) begin
         demand = lqdp_pkg::DEMAND_RUN;
      end else begin
         demand = lqdp_pkg::DEMAND_HOLD;
      end
   end

   // Pump lanes.
   lqdp_pump_bank #(
      .PUMP_COUNT (PUMP_COUNT)
   ) u_pump_bank (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .now_ms           (now_ff),
      .demand           (demand),
      .duty_mask        (duty_mask_ff),
      .present_mask     (present_mask_ff),
      .running_mask     (running_ff),
      .startup_limit_ms (startup_limit_ff),
      .enable_mask      (enable_next),
      .start_fault_mask (fault_next)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (advance) begin
         enable_ff <= enable_next;
         fault_ff  <= fault_next;
         demand_ff <= demand;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_enable_mask      = enable_ff;
   assign rsp_start_fault_mask = fault_ff;
   assign rsp_demand           = demand_ff;

endmodule

@@ hw/rtl/lqdp_level_qual.sv @@
// Float switch tracker: last on and off times and the qualified level.
module lqdp_level_qual (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  lqdp_pkg::time_type       now_ms,
   input  logic                     switch_on,
   input  lqdp_pkg::time_type       level_delay_ms,
   output lqdp_pkg::level_qual_type qual
);

   lqdp_pkg::time_type last_on_ff;
   lqdp_pkg::time_type last_on_in;
   lqdp_pkg::time_type last_off_ff;
   lqdp_pkg::time_type last_off_in;
   lqdp_pkg::time_type since_on;
   lqdp_pkg::time_type since_off;

   // Elapsed times use the stored opposite level, so the update of this item
   // never feeds its own decision. Subtraction wraps modulo 2^32.
   always_comb begin
      since_on     = now_ms - last_on_ff;
      since_off    = now_ms - last_off_ff;
      qual.qual_on  = switch_on && (since_off > level_delay_ms);
      qual.qual_off = !switch_on && (since_on > level_delay_ms);
   end

   // Record this item's time as the last time the switch was seen at its level.
   always_comb begin
      last_on_in  = last_on_ff;
      last_off_in = last_off_ff;
      if (advance) begin
         if (switch_on) begin
            last_on_in = now_ms;
         end else begin
            last_off_in = now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_on_ff  <= '0;
         last_off_ff <= '0;
      end else begin
         last_on_ff  <= last_on_in;
         last_off_ff <= last_off_in;
      end
   end

endmodule

@@ hw/rtl/lqdp_pump_bank.sv @@
// Pump lanes: started flags, start times and start-fault detection.
module lqdp_pump_bank #(
   parameter int PUMP_COUNT = lqdp_pkg::PumpCountDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  lqdp_pkg::time_type       now_ms,
   input  lqdp_pkg::demand_type     demand,
   input  logic [PUMP_COUNT-1:0]    duty_mask,
   input  logic [PUMP_COUNT-1:0]    present_mask,
   input  logic [PUMP_COUNT-1:0]    running_mask,
   input  lqdp_pkg::time_type       startup_limit_ms,
   output logic [PUMP_COUNT-1:0]    enable_mask,
   output logic [PUMP_COUNT-1:0]    start_fault_mask
);

   logic [PUMP_COUNT-1:0] started_ff;
   logic [PUMP_COUNT-1:0] started_in;
   lqdp_pkg::time_type    start_time_ff [PUMP_COUNT];
   lqdp_pkg::time_type    start_time_in [PUMP_COUNT];
   lqdp_pkg::time_type    elapsed       [PUMP_COUNT];
   logic [PUMP_COUNT-1:0] run_lane;
   logic [PUMP_COUNT-1:0] stop_lane;

   // Each lane works alone: apply the demand, then check the start-up limit
   // against the updated start time.
   always_comb begin
      for (int i = 0; i < PUMP_COUNT; i++) begin
         run_lane[i]  = present_mask[i] && duty_mask[i] &&
                        (demand == lqdp_pkg::DEMAND_RUN);
         stop_lane[i] = present_mask[i] && (demand == lqdp_pkg::DEMAND_STOP);
         if (run_lane[i]) begin
            started_in[i] = 1'b1;
         end else if (stop_lane[i]) begin
            started_in[i] = 1'b0;
         end else begin
            started_in[i] = started_ff[i];
         end
         // A pump keeps its earlier start time while it stays started.
         if (run_lane[i] && !started_ff[i]) begin
            start_time_in[i] = now_ms;
         end else begin
            start_time_in[i] = start_time_ff[i];
         end
         elapsed[i]          = now_ms - start_time_in[i];
         start_fault_mask[i] = started_in[i] && !running_mask[i] &&
                               (elapsed[i] >= startup_limit_ms);
      end
      enable_mask = started_in;
   end

   // Started flags are control state and are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= '0;
      end else if (advance) begin
         started_ff <= started_in;
      end
   end

   // Start times are only read while the pump is started.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < PUMP_COUNT; i++) begin
            start_time_ff[i] <= start_time_in[i];
         end
      end
   end

endmodule
